// File: hdl/qbbc_pkg.sv
package qbbc_pkg;

   localparam int SCREEN_ROWS = 256;
   localparam int BAND_ROWS   = 16;   // power of two: band index is a shift
   localparam int BANDS       = 16;
   localparam int MAX_PIECES  = 16;

   localparam int ROW_W      = (SCREEN_ROWS > 1) ? $clog2(SCREEN_ROWS) : 1;
   localparam int BAND_W     = (BANDS > 1) ? $clog2(BANDS) : 1;
   localparam int BIDX_W     = (ROW_W > BAND_W) ? ROW_W : BAND_W;
   localparam int BAND_SHIFT = $clog2(BAND_ROWS);
   localparam int PIECE_W    = (MAX_PIECES > 1) ? $clog2(MAX_PIECES) : 1;

   // rows skipped: up to screen height plus the 16 bit negative top
   localparam int DELTA_W = 18;
   localparam int PROD_W  = 32 + DELTA_W;
   localparam int SUM_W   = PROD_W + 1;

   localparam logic signed [16:0] SCREEN_ROWS_S = 17'(SCREEN_ROWS);

   localparam logic [15:0]        DEPTH_HI = 16'hFFFF;
   localparam logic signed [31:0] S32_LO   = 32'sh8000_0000;
   localparam logic signed [31:0] S32_HI   = 32'sh7FFF_FFFF;

   localparam logic signed [PROD_W-1:0] PROD_ZERO = '0;

   typedef struct packed {
      logic signed [15:0] quad_top;
      logic signed [15:0] quad_bottom;
      logic [15:0]        depth_start;
      logic signed [31:0] depth_step_y;
      logic               textured;
      logic signed [31:0] u_start;
      logic signed [31:0] v_start;
      logic signed [31:0] w_start;
      logic signed [31:0] u_step_y;
      logic signed [31:0] v_step_y;
      logic signed [31:0] w_step_y;
   } req_word_type;

   typedef struct packed {
      logic [3:0]         band;
      logic [7:0]         out_top;
      logic [7:0]         out_bottom;
      logic [15:0]        out_depth;
      logic signed [31:0] out_u;
      logic signed [31:0] out_v;
      logic signed [31:0] out_w;
      logic               out_textured;
      logic               untouched;
      logic               last_piece;
   } rsp_word_type;

endpackage

// File: hdl/qbbc_if.sv
interface qbbc_req_if;
   logic                  valid;
   logic                  ready;
   qbbc_pkg::req_word_type word;

   modport source (output valid, output word, input ready);
   modport sink   (input valid, input word, output ready);
endinterface

interface qbbc_rsp_if;
   logic                  valid;
   logic                  ready;
   qbbc_pkg::rsp_word_type word;

   modport source (output valid, output word, input ready);
   modport sink   (input valid, input word, output ready);
endinterface

// File: hdl/quad_band_binner_clipper_core.sv
// Quad band binner/clipper. Each req word is one quad; it gives one rsp word per screen
// band it covers (at most 16), in band order, with last_piece on the final one; a quad off
// screen, inverted or starting past the last band gives none. The band generator emits one
// piece per cycle while rsp does not stall, and takes the next quad in the cycle its final
// piece leaves. Pieces then pass a clip stage, a multiply stage (four 32x18 products) and
// an add/saturate stage into the rsp register; a piece is held in turn in the generator,
// clip, product and rsp registers. A stall on rsp holds the whole pipe.
module quad_band_binner_clipper_core (
   input  logic        clock,
   input  logic        reset,
   qbbc_req_if.sink    req,
   qbbc_rsp_if.source  rsp
);

   typedef struct packed {
      qbbc_pkg::req_word_type         item;
      logic [qbbc_pkg::ROW_W-1:0]     ctop;
      logic [qbbc_pkg::ROW_W-1:0]     cbot;
      logic [qbbc_pkg::BIDX_W-1:0]    last;
      logic                           pass;
   } gen_type;

   typedef struct packed {
      qbbc_pkg::req_word_type          item;
      logic [3:0]                      band;
      logic [7:0]                      top;
      logic [7:0]                      bot;
      logic signed [qbbc_pkg::DELTA_W-1:0] delta;
      logic                            pass;
      logic                            last;
   } clip_type;

   typedef struct packed {
      logic [15:0]                         depth;
      logic signed [31:0]                  u;
      logic signed [31:0]                  v;
      logic signed [31:0]                  w;
      logic signed [qbbc_pkg::PROD_W-1:0]  dp;
      logic signed [qbbc_pkg::PROD_W-1:0]  up;
      logic signed [qbbc_pkg::PROD_W-1:0]  vp;
      logic signed [qbbc_pkg::PROD_W-1:0]  wp;
      logic [3:0]                          band;
      logic [7:0]                          top;
      logic [7:0]                          bot;
      logic                                tex;
      logic                                pass;
      logic                                last;
   } prod_type;

   function automatic logic [15:0] sat_depth(input logic signed [qbbc_pkg::SUM_W-1:0] x);
      if (x < 0)
         return '0;
      else if (x > $signed(qbbc_pkg::SUM_W'(qbbc_pkg::DEPTH_HI)))
         return qbbc_pkg::DEPTH_HI;
      else
         return x[15:0];
   endfunction

   function automatic logic signed [31:0] sat_s32(
      input logic signed [qbbc_pkg::SUM_W-1:0] x);
      if (x < qbbc_pkg::SUM_W'(qbbc_pkg::S32_LO))
         return qbbc_pkg::S32_LO;
      else if (x > qbbc_pkg::SUM_W'(qbbc_pkg::S32_HI))
         return qbbc_pkg::S32_HI;
      else
         return x[31:0];
   endfunction

   logic advance;

   // input decode
   logic signed [16:0]            top_x, bot_x;
   logic                          off_screen, bot_clip, empty;
   logic [qbbc_pkg::ROW_W-1:0]    ctop, cbot;
   logic [qbbc_pkg::BIDX_W-1:0]   first, last_raw, last;
   logic                          load;

   // band generator
   logic                          gen_valid_ff, gen_valid_in;
   gen_type                       gen_ff, gen_in;
   logic [qbbc_pkg::BIDX_W-1:0]   band_ff, band_in;
   logic [qbbc_pkg::PIECE_W-1:0]  count_ff, count_in;
   logic [qbbc_pkg::ROW_W-1:0]    bmin, pmin, pmax;
   logic                          piece_last, emit;

   logic      clip_valid_ff, clip_valid_in;
   clip_type  clip_ff, clip_in;
   logic      prod_valid_ff, prod_valid_in;
   prod_type  prod_ff, prod_in;
   logic                    out_valid_ff, out_valid_in;
   qbbc_pkg::rsp_word_type  out_ff, out_in;

   logic signed [qbbc_pkg::SUM_W-1:0] dsum, usum, vsum, wsum;

   assign advance = !out_valid_ff || rsp.ready;

   always_comb begin
      top_x      = 17'(req.word.quad_top);
      bot_x      = 17'(req.word.quad_bottom);
      bot_clip   = bot_x >= qbbc_pkg::SCREEN_ROWS_S;
      off_screen = bot_x[16] || top_x >= qbbc_pkg::SCREEN_ROWS_S || top_x > bot_x;
      ctop       = top_x[16] ? '0 : top_x[qbbc_pkg::ROW_W-1:0];
      cbot       = bot_clip ? qbbc_pkg::ROW_W'(qbbc_pkg::SCREEN_ROWS - 1)
                            : bot_x[qbbc_pkg::ROW_W-1:0];
      first      = qbbc_pkg::BIDX_W'(ctop >> qbbc_pkg::BAND_SHIFT);
      last_raw   = qbbc_pkg::BIDX_W'(cbot >> qbbc_pkg::BAND_SHIFT);
      last       = (last_raw > qbbc_pkg::BIDX_W'(qbbc_pkg::BANDS - 1))
                   ? qbbc_pkg::BIDX_W'(qbbc_pkg::BANDS - 1) : last_raw;
      empty      = off_screen || first > last;
   end

   // piece geometry for the current band
   always_comb begin
      bmin = qbbc_pkg::ROW_W'(32'(band_ff) << qbbc_pkg::BAND_SHIFT);
      pmin = (gen_ff.ctop > bmin) ? gen_ff.ctop : bmin;
      // the band holding cbot ends at cbot; earlier bands end at their own last row
      pmax = (band_ff == qbbc_pkg::BIDX_W'(gen_ff.cbot >> qbbc_pkg::BAND_SHIFT))
             ? gen_ff.cbot : qbbc_pkg::ROW_W'(bmin + qbbc_pkg::ROW_W'(qbbc_pkg::BAND_ROWS - 1));
      piece_last = (band_ff == gen_ff.last) ||
                   (count_ff == qbbc_pkg::PIECE_W'(qbbc_pkg::MAX_PIECES - 1));
      emit = gen_valid_ff && advance;
   end

   assign req.ready = !gen_valid_ff || (emit && piece_last);
   assign load      = req.valid && req.ready;

   always_comb begin
      gen_valid_in = gen_valid_ff;
      gen_in       = gen_ff;
      band_in      = band_ff;
      count_in     = count_ff;
      if (emit) begin
         if (piece_last) begin
            gen_valid_in = 1'b0;
         end else begin
            band_in  = band_ff + 1'b1;
            count_in = count_ff + 1'b1;
         end
      end
      if (load) begin
         gen_valid_in = !empty;
         gen_in.item  = req.word;
         gen_in.ctop  = ctop;
         gen_in.cbot  = cbot;
         gen_in.last  = last;
         gen_in.pass  = (first == last) && !top_x[16] && !bot_clip;
         band_in      = first;
         count_in     = '0;
      end
   end

   always_comb begin
      clip_valid_in = clip_valid_ff;
      clip_in       = clip_ff;
      if (advance) begin
         clip_valid_in = gen_valid_ff;
         clip_in.item  = gen_ff.item;
         clip_in.band  = 4'(band_ff);
         clip_in.top   = 8'(pmin);
         clip_in.bot   = 8'(pmax);
         clip_in.delta = $signed(qbbc_pkg::DELTA_W'(pmin))
                         - qbbc_pkg::DELTA_W'(gen_ff.item.quad_top);
         clip_in.pass  = gen_ff.pass;
         clip_in.last  = piece_last;
      end
   end

   // a passed-through quad has zero rows skipped, so it needs no bypass
   always_comb begin
      prod_valid_in = prod_valid_ff;
      prod_in       = prod_ff;
      if (advance) begin
         prod_valid_in = clip_valid_ff;
         prod_in.depth = clip_ff.item.depth_start;
         prod_in.u     = clip_ff.item.u_start;
         prod_in.v     = clip_ff.item.v_start;
         prod_in.w     = clip_ff.item.w_start;
         prod_in.dp    = clip_ff.item.depth_step_y * clip_ff.delta;
         // both arms signed so the products stay signed
         prod_in.up    = clip_ff.item.textured ? clip_ff.item.u_step_y * clip_ff.delta
                                               : qbbc_pkg::PROD_ZERO;
         prod_in.vp    = clip_ff.item.textured ? clip_ff.item.v_step_y * clip_ff.delta
                                               : qbbc_pkg::PROD_ZERO;
         prod_in.wp    = clip_ff.item.textured ? clip_ff.item.w_step_y * clip_ff.delta
                                               : qbbc_pkg::PROD_ZERO;
         prod_in.band  = clip_ff.band;
         prod_in.top   = clip_ff.top;
         prod_in.bot   = clip_ff.bot;
         prod_in.tex   = clip_ff.item.textured;
         prod_in.pass  = clip_ff.pass;
         prod_in.last  = clip_ff.last;
      end
   end

   always_comb begin
      dsum = $signed(qbbc_pkg::SUM_W'(prod_ff.depth)) + qbbc_pkg::SUM_W'(prod_ff.dp);
      usum = qbbc_pkg::SUM_W'(prod_ff.u) + qbbc_pkg::SUM_W'(prod_ff.up);
      vsum = qbbc_pkg::SUM_W'(prod_ff.v) + qbbc_pkg::SUM_W'(prod_ff.vp);
      wsum = qbbc_pkg::SUM_W'(prod_ff.w) + qbbc_pkg::SUM_W'(prod_ff.wp);
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (advance) begin
         out_valid_in        = prod_valid_ff;
         out_in.band         = prod_ff.band;
         out_in.out_top      = prod_ff.top;
         out_in.out_bottom   = prod_ff.bot;
         out_in.out_depth    = sat_depth(dsum);
         out_in.out_u        = sat_s32(usum);
         out_in.out_v        = sat_s32(vsum);
         out_in.out_w        = sat_s32(wsum);
         out_in.out_textured = prod_ff.tex;
         out_in.untouched    = prod_ff.pass;
         out_in.last_piece   = prod_ff.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gen_valid_ff  <= 1'b0;
         clip_valid_ff <= 1'b0;
         prod_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
         band_ff       <= '0;
         count_ff      <= '0;
      end else begin
         gen_valid_ff  <= gen_valid_in;
         clip_valid_ff <= clip_valid_in;
         prod_valid_ff <= prod_valid_in;
         out_valid_ff  <= out_valid_in;
         band_ff       <= band_in;
         count_ff      <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      gen_ff  <= gen_in;
      clip_ff <= clip_in;
      prod_ff <= prod_in;
      out_ff  <= out_in;
   end

   assign rsp.valid = out_valid_ff;
   assign rsp.word  = out_ff;

endmodule

// File: tb/tb_quad_band_binner_clipper_core.sv
module tb_quad_band_binner_clipper_core;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 16;
   localparam int RANDOM_QUADS = 140;

   logic clock = 1'b0;
   logic reset = 1'b1;

   qbbc_req_if req_if ();
   qbbc_rsp_if rsp_if ();

   quad_band_binner_clipper_core i_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_if),
      .rsp   (rsp_if)
   );

   always #10 clock = ~clock;

   qbbc_pkg::rsp_word_type expected_pieces[$];
   int           mismatch_count = 0;
   int           cycle_count    = 0;
   int           req_gap_max    = 9;
   int           rsp_stall_max  = 9;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d pieces outstanding", cycle_count,
                  expected_pieces.size());
         $display("end of test: mismatches");
         $finish;
      end
   end

   task automatic report_mismatch(input string msg);
      $display("[%0t] MISMATCH: %s", $realtime, msg);
      mismatch_count++;
   endtask

   task automatic compare_field(input string name, input logic [63:0] got,
                                input logic [63:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
   endtask

   function automatic logic [31:0] clamp_s32(input longint value);
      if (value < longint'(qbbc_pkg::S32_LO)) return qbbc_pkg::S32_LO;
      if (value > longint'(qbbc_pkg::S32_HI)) return qbbc_pkg::S32_HI;
      return value[31:0];
   endfunction

   // Queues the band pieces one quad produces; returns how many.
   function automatic int bin_quad(input qbbc_pkg::req_word_type q);
      longint       top, bot, ctop, cbot, first, last, bmin, bmax, pmin, pmax, delta, depth;
      longint       d_step, u0, v0, w0, du, dv, dw;
      bit           pass;
      int           n;
      qbbc_pkg::rsp_word_type piece;
      top    = longint'($signed(q.quad_top));
      bot    = longint'($signed(q.quad_bottom));
      depth  = longint'(q.depth_start);
      d_step = longint'($signed(q.depth_step_y));
      u0     = longint'($signed(q.u_start));
      v0     = longint'($signed(q.v_start));
      w0     = longint'($signed(q.w_start));
      du     = longint'($signed(q.u_step_y));
      dv     = longint'($signed(q.v_step_y));
      dw     = longint'($signed(q.w_step_y));
      n      = 0;
      if (bot < 0 || top >= qbbc_pkg::SCREEN_ROWS || top > bot) return 0;
      ctop  = (top < 0) ? 0 : top;
      cbot  = (bot >= qbbc_pkg::SCREEN_ROWS) ? qbbc_pkg::SCREEN_ROWS - 1 : bot;
      first = ctop / qbbc_pkg::BAND_ROWS;
      last  = cbot / qbbc_pkg::BAND_ROWS;
      if (last >= qbbc_pkg::BANDS) last = qbbc_pkg::BANDS - 1;
      if (first > last) return 0;
      pass = (first == last) && (ctop == top) && (cbot == bot);
      for (longint b = first; b <= last && n < qbbc_pkg::MAX_PIECES; b++) begin
         bmin  = b * qbbc_pkg::BAND_ROWS;
         bmax  = bmin + qbbc_pkg::BAND_ROWS - 1;
         pmin  = (ctop > bmin) ? ctop : bmin;
         pmax  = (cbot < bmax) ? cbot : bmax;
         delta = pmin - top;
         piece = '0;
         piece.band         = 4'(b);
         piece.out_top      = 8'(pmin);
         piece.out_bottom   = 8'(pmax);
         piece.out_depth    = q.depth_start;
         piece.out_u        = q.u_start;
         piece.out_v        = q.v_start;
         piece.out_w        = q.w_start;
         piece.out_textured = q.textured;
         piece.untouched    = pass;
         piece.last_piece   = (b == last) || (n == qbbc_pkg::MAX_PIECES - 1);
         if (!pass) begin
            depth = longint'(q.depth_start) + d_step * delta;
            if (depth < 0) piece.out_depth = '0;
            else if (depth > longint'(qbbc_pkg::DEPTH_HI)) piece.out_depth = qbbc_pkg::DEPTH_HI;
            else piece.out_depth = depth[15:0];
            if (q.textured) begin
               piece.out_u = clamp_s32(u0 + du * delta);
               piece.out_v = clamp_s32(v0 + dv * delta);
               piece.out_w = clamp_s32(w0 + dw * delta);
            end
         end
         expected_pieces.push_back(piece);
         n++;
      end
      return n;
   endfunction

   task automatic send_quad(input qbbc_pkg::req_word_type q, output int pieces);
      int gap;
      gap = $urandom_range(0, req_gap_max);
      @(negedge clock);
      if (gap > 0) begin
         req_if.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.word  = q;
      req_if.valid = 1'b1;
      do @(posedge clock); while (!req_if.ready);
      pieces = bin_quad(q);
   endtask

   // Random attributes; small steps most of the time so rebasing stays in range.
   function automatic qbbc_pkg::req_word_type make_quad(input int top, input int bottom,
                                                        input bit textured);
      qbbc_pkg::req_word_type q;
      q.quad_top    = 16'(top);
      q.quad_bottom = 16'(bottom);
      q.depth_start = 16'($urandom);
      q.textured    = textured;
      q.u_start     = $urandom;
      q.v_start     = $urandom;
      q.w_start     = $urandom;
      if ($urandom_range(0, 3) == 0) begin
         q.depth_step_y = $urandom;
         q.u_step_y     = $urandom;
         q.v_step_y     = $urandom;
         q.w_step_y     = $urandom;
      end else begin
         q.depth_step_y = 32'(int'($urandom_range(0, 4000)) - 2000);
         q.u_step_y     = 32'(int'($urandom_range(0, 200000)) - 100000);
         q.v_step_y     = 32'(int'($urandom_range(0, 200000)) - 100000);
         q.w_step_y     = 32'(int'($urandom_range(0, 200000)) - 100000);
      end
      return q;
   endfunction

   // Result side: a random stall before each word, then ready until one is taken.
   initial begin
      int stall;
      rsp_if.ready = 1'b0;
      @(negedge clock);
      wait (!reset);
      forever begin
         stall = $urandom_range(0, rsp_stall_max);
         @(negedge clock);
         if (stall > 0) begin
            rsp_if.ready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_if.ready = 1'b1;
         do @(posedge clock); while (!rsp_if.valid);
      end
   end

   always @(posedge clock) begin
      qbbc_pkg::rsp_word_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_pieces.size() == 0) begin
            report_mismatch($sformatf("unexpected word band %0d rows %0d..%0d",
                                      rsp_if.word.band, rsp_if.word.out_top,
                                      rsp_if.word.out_bottom));
         end else begin
            want = expected_pieces.pop_front();
            compare_field("band",         rsp_if.word.band,         want.band);
            compare_field("out_top",      rsp_if.word.out_top,      want.out_top);
            compare_field("out_bottom",   rsp_if.word.out_bottom,   want.out_bottom);
            compare_field("out_depth",    rsp_if.word.out_depth,    want.out_depth);
            compare_field("out_u",        rsp_if.word.out_u,        want.out_u);
            compare_field("out_v",        rsp_if.word.out_v,        want.out_v);
            compare_field("out_w",        rsp_if.word.out_w,        want.out_w);
            compare_field("out_textured", rsp_if.word.out_textured, want.out_textured);
            compare_field("untouched",    rsp_if.word.untouched,    want.untouched);
            compare_field("last_piece",   rsp_if.word.last_piece,   want.last_piece);
         end
      end
   end

   // Off screen, inverted and extreme-row quads: none of these give a word.
   task automatic test_off_screen();
      int n;
      send_quad(make_quad(0, -1, 1'b1), n);
      send_quad(make_quad(256, 300, 1'b1), n);
      send_quad(make_quad(100, 99, 1'b0), n);
      send_quad(make_quad(-32768, -32768, 1'b1), n);
      send_quad(make_quad(32767, 32767, 1'b0), n);
      send_quad(make_quad(32767, -32768, 1'b1), n);
   endtask

   task automatic test_pass_through();
      int n;
      send_quad(make_quad(16, 31, 1'b1), n);
      send_quad(make_quad(0, 0, 1'b1), n);
      send_quad(make_quad(255, 255, 1'b0), n);
      send_quad(make_quad(40, 45, 1'b0), n);
   endtask

   task automatic test_clipping();
      qbbc_pkg::req_word_type q;
      int           n;
      send_quad(make_quad(-32768, 32767, 1'b1), n);
      send_quad(make_quad(-5, 20, 1'b1), n);
      send_quad(make_quad(250, 300, 1'b1), n);
      send_quad(make_quad(10, 20, 1'b1), n);
      send_quad(make_quad(0, 255, 1'b0), n);
      send_quad(make_quad(15, 16, 1'b1), n);
      // untextured with clipping: u, v, w must come through as given
      q = make_quad(-100, 70, 1'b0);
      q.u_step_y = 32'h7FFF_FFFF;
      send_quad(q, n);
   endtask

   task automatic test_saturation();
      qbbc_pkg::req_word_type q;
      int           n;
      q = make_quad(-32768, 40, 1'b1);
      q.depth_start  = 16'hFFFF;
      q.depth_step_y = qbbc_pkg::S32_HI;
      q.u_start = qbbc_pkg::S32_HI; q.u_step_y = qbbc_pkg::S32_HI;
      q.v_start = qbbc_pkg::S32_LO; q.v_step_y = qbbc_pkg::S32_LO;
      q.w_start = '0;               q.w_step_y = qbbc_pkg::S32_LO;
      send_quad(q, n);
      q = make_quad(3, 200, 1'b1);
      q.depth_start  = '0;
      q.depth_step_y = qbbc_pkg::S32_LO;
      q.u_start = qbbc_pkg::S32_LO; q.u_step_y = 32'hFFFF_FFFF;
      q.v_start = qbbc_pkg::S32_HI; q.v_step_y = 32'd1;
      q.w_start = qbbc_pkg::S32_HI; q.w_step_y = qbbc_pkg::S32_HI;
      send_quad(q, n);
      q = make_quad(5, 60, 1'b1);
      q.depth_start  = 16'hFFFF;
      q.depth_step_y = '0;
      q.u_step_y = '0; q.v_step_y = '0; q.w_step_y = '0;
      send_quad(q, n);
   endtask

   task automatic test_random();
      qbbc_pkg::req_word_type q;
      int           n, top, span, kind;
      for (int i = 0; i < RANDOM_QUADS; i++) begin
         // switch pacing now and then: full idling, none at all, stalls only
         if ($urandom_range(0, 24) == 0) begin
            kind          = $urandom_range(0, 2);
            req_gap_max   = (kind == 1) ? 0 : 9;
            rsp_stall_max = (kind == 0) ? 9 : ((kind == 1) ? 0 : 9);
            if (kind == 2) req_gap_max = 0;
         end
         kind = $urandom_range(0, 9);
         if (kind == 0) begin
            q = make_quad(0, 0, 1'($urandom_range(0, 1)));
            q.quad_top    = 16'($urandom);
            q.quad_bottom = 16'($urandom);
         end else if (kind == 1) begin
            top = int'($urandom_range(0, 400)) - 100;
            q   = make_quad(top, top - int'($urandom_range(1, 50)),
                            1'($urandom_range(0, 1)));
         end else begin
            top  = int'($urandom_range(0, 300)) - 30;
            span = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 320) : $urandom_range(0, 30);
            q    = make_quad(top, top + span, $urandom_range(0, 3) != 0);
         end
         send_quad(q, n);
      end
   endtask

   initial begin
      req_if.valid = 1'b0;
      req_if.word  = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_off_screen();
      test_pass_through();
      test_clipping();
      test_saturation();
      test_random();

      @(negedge clock);
      req_if.valid = 1'b0;
      wait (expected_pieces.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
